/* hdl/flp49_pkg.sv */
`default_nettype none

package flp49_pkg;

   // Fixed field widths of the ports
   localparam int IN_BITS  = 12;
   localparam int OUT_BITS = 14;

   // Output limits, as magnitudes
   localparam int OUT_POS_LIMIT = 8191;
   localparam int OUT_NEG_LIMIT = 8192;

   // Sample bits consumed per cycle by the serial multiplier
   localparam int DIGIT_BITS = 4;

   // Low-pass design, fs 100 Hz, fc 10 Hz, Kaiser window, Q1.15
   localparam int DESIGN_TAPS = 49;
   localparam logic signed [15:0] COEF_Q15 [DESIGN_TAPS] = '{
      16'sd255,   16'sd431,   16'sd451,   16'sd292,   16'sd0,
      -16'sd323,  -16'sd551,  -16'sd584,  -16'sd383,  16'sd0,
      16'sd438,   16'sd763,   16'sd827,   16'sd557,   16'sd0,
      -16'sd681,  -16'sd1240, -16'sd1417, -16'sd1022, 16'sd0,
      16'sd1533,  16'sd3307,  16'sd4960,  16'sd6131,  16'sd6554,
      16'sd6131,  16'sd4960,  16'sd3307,  16'sd1533,  16'sd0,
      -16'sd1022, -16'sd1417, -16'sd1240, -16'sd681,  16'sd0,
      16'sd557,   16'sd827,   16'sd763,   16'sd438,   16'sd0,
      -16'sd383,  -16'sd584,  -16'sd551,  -16'sd323,  16'sd0,
      16'sd292,   16'sd451,   16'sd431,   16'sd255
   };

   // Delay line control
   typedef struct packed {
      logic start;    // point the read side at the sample one step old
      logic advance;  // step the read side one sample further back
      logic push;     // write the newest sample, retire the oldest
   } dl_ctl_type;

   // Serial multiply-accumulate control
   typedef struct packed {
      logic clear;    // zero accumulator and product
      logic load;     // take a new sample and coefficient
      logic step;     // consume one digit of the sample
      logic add;      // fold the finished product into the accumulator
   } mac_ctl_type;

   // Coefficient of one tap with frac fraction bits; zero beyond the design
   function automatic logic signed [31:0] tap_coef(input int idx, input int frac);
      logic signed [31:0] v;
      logic        [31:0] mag;
      int                 s;
      v   = 32'sd0;
      mag = 32'd0;
      s   = 0;
      if ((idx >= 0) && (idx < DESIGN_TAPS)) begin
         v = 32'(COEF_Q15[idx]);
         if (frac >= 15) begin
            v = v <<< (frac - 15);
         end else begin
            s   = 15 - frac;
            mag = (v < 0) ? 32'(-v) : 32'(v);
            mag = (mag + (32'd1 << (s - 1))) >> s;
            v   = (v < 0) ? -$signed(mag) : $signed(mag);
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

/* hdl/flp49_delay_line.sv */
`default_nettype none

module flp49_delay_line #(
   parameter int DEPTH       = 48,
   parameter int SAMPLE_BITS = 12,
   parameter int AGE_BITS    = 6
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire flp49_pkg::dl_ctl_type    ctl,
   input  wire logic [AGE_BITS-1:0]      age,
   input  wire logic [SAMPLE_BITS-1:0]   push_data,
   output logic      [SAMPLE_BITS-1:0]   rd_sample
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [AGE_BITS-1:0] FULL     = AGE_BITS'(DEPTH);

   logic [SAMPLE_BITS-1:0] mem_ff [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;
   logic                   rd_valid_ff;
   logic [PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AGE_BITS-1:0]    fill_ff, fill_in;

   // Sample memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      rd_data_ff  <= mem_ff[rd_ptr_ff];
      rd_valid_ff <= (age <= fill_ff);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (ctl.start) begin
         rd_ptr_in = (wr_ptr_ff == '0) ? LAST_PTR : wr_ptr_ff - 1'b1;
      end else if (ctl.advance) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? LAST_PTR : rd_ptr_ff - 1'b1;
      end
      if (ctl.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         // Entries never written read as zero until the line has filled
         if (fill_ff != FULL) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   assign rd_sample = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

/* hdl/flp49_serial_mac.sv */
`default_nettype none

module flp49_serial_mac #(
   parameter int SAMPLE_BITS = 12,
   parameter int COEF_BITS   = 16,
   parameter int ACC_BITS    = 40
) (
   input  wire logic                          clock,
   input  wire flp49_pkg::mac_ctl_type        ctl,
   input  wire logic        [SAMPLE_BITS-1:0] sample,
   input  wire logic signed [COEF_BITS-1:0]   coef,
   output logic signed      [ACC_BITS-1:0]    acc
);

   localparam int DIGIT_BITS  = flp49_pkg::DIGIT_BITS;
   localparam int DIGIT_COUNT = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int SR_BITS     = DIGIT_COUNT * DIGIT_BITS;
   localparam int PROD_BITS   = SR_BITS + COEF_BITS;

   logic        [SR_BITS-1:0]            sr_ff, sr_in;
   logic signed [COEF_BITS-1:0]          coef_ff, coef_in;
   logic signed [PROD_BITS-1:0]          prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]           acc_ff, acc_in;
   logic        [DIGIT_BITS-1:0]         digit;
   logic signed [COEF_BITS+DIGIT_BITS:0] term;

   // Most significant digit first: product = product * 2^DIGIT_BITS + coef * digit
   assign digit = sr_ff[SR_BITS-1 -: DIGIT_BITS];
   assign term  = $signed({1'b0, digit}) * coef_ff;

   always_comb begin
      sr_in   = sr_ff;
      coef_in = coef_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctl.clear) begin
         prod_in = '0;
         acc_in  = '0;
      end
      if (ctl.load) begin
         sr_in   = SR_BITS'(sample);
         coef_in = coef;
         prod_in = '0;
      end
      if (ctl.step) begin
         sr_in   = sr_ff << DIGIT_BITS;
         prod_in = (prod_ff <<< DIGIT_BITS) + PROD_BITS'(term);
      end
      if (ctl.add) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      sr_ff   <= sr_in;
      coef_ff <= coef_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

/* hdl/fir_lowpass_49tap.sv */
`default_nettype none

// Channel   Ports                          Width  Meaning
// req       req_valid/req_ready            12     req_sample_mv, unsigned millivolts
// rsp       rsp_valid/rsp_ready            14     rsp_filtered_mv, two's complement mV
//
// The serial multiplier, which eats four sample bits per cycle and is shared by
// all taps in turn, sets the time from transfer to result; a new transfer is
// taken the cycle after the result is loaded, so the block takes no new sample
// while one is still being filtered.
// Reset clears control state only; the delay line uses a fill count, so
// unwritten entries read as zero with no clearing pass.
// A stalled rsp channel holds the finished item in DONE; a new req transfer is
// taken while an earlier result still waits in the output register.

module fir_lowpass_49tap #(
   parameter int TAP_COUNT      = 49,
   parameter int SAMPLE_BITS    = 12,
   parameter int COEF_FRAC_BITS = 15
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [flp49_pkg::IN_BITS-1:0] req_sample_mv,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed     [flp49_pkg::OUT_BITS-1:0] rsp_filtered_mv
);

   localparam int DIGIT_BITS  = flp49_pkg::DIGIT_BITS;
   localparam int DIGIT_COUNT = (SAMPLE_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DIG_CNT_BITS = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int SR_BITS     = DIGIT_COUNT * DIGIT_BITS;
   localparam int COEF_BITS   = (COEF_FRAC_BITS >= 15) ? COEF_FRAC_BITS + 1 : 16;
   localparam int TAP_BITS    = $clog2(TAP_COUNT);
   localparam int ACC_BITS    = SR_BITS + COEF_BITS + TAP_BITS;
   localparam int CMP_BITS    = (ACC_BITS > 16) ? ACC_BITS : 16;
   localparam int MAG_BITS    = flp49_pkg::OUT_BITS + 1;
   localparam int OUT_BITS    = flp49_pkg::OUT_BITS;

   localparam logic [TAP_BITS-1:0]     LAST_TAP   = TAP_BITS'(TAP_COUNT - 1);
   localparam logic [DIG_CNT_BITS-1:0] LAST_DIGIT = DIG_CNT_BITS'(DIGIT_COUNT - 1);
   localparam logic [CMP_BITS-1:0]     POS_LIMIT  = CMP_BITS'(flp49_pkg::OUT_POS_LIMIT);
   localparam logic [CMP_BITS-1:0]     NEG_LIMIT  = CMP_BITS'(flp49_pkg::OUT_NEG_LIMIT);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_MULT  = 7'b0001000,
      ST_SUM   = 7'b0010000,
      ST_ROUND = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [TAP_BITS-1:0]         tap_ff, tap_in;
   logic [DIG_CNT_BITS-1:0]     digit_ff, digit_in;
   logic [SAMPLE_BITS-1:0]      newest_ff, newest_in;
   logic                        neg_ff, neg_in;
   logic [MAG_BITS-1:0]         mag_ff, mag_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]         rsp_data_ff, rsp_data_in;

   flp49_pkg::dl_ctl_type       dl_ctl;
   flp49_pkg::mac_ctl_type      mac_ctl;
   logic [SAMPLE_BITS-1:0]      dl_sample;
   logic [SAMPLE_BITS-1:0]      load_sample;
   logic signed [COEF_BITS-1:0] coef_sel;
   logic signed [ACC_BITS-1:0]  acc;
   logic [ACC_BITS-1:0]         acc_abs;
   logic [CMP_BITS-1:0]         acc_int;
   logic                        req_xfer;
   logic                        out_free;

   // Past samples, oldest retired on each push
   flp49_delay_line #(
      .DEPTH       (TAP_COUNT - 1),
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_BITS    (TAP_BITS)
   ) u_delay_line (
      .clock     (clock),
      .reset     (reset),
      .ctl       (dl_ctl),
      .age       (tap_ff),
      .push_data (newest_ff),
      .rd_sample (dl_sample)
   );

   // Shared digit-serial multiply-accumulate
   flp49_serial_mac #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS),
      .ACC_BITS    (ACC_BITS)
   ) u_serial_mac (
      .clock  (clock),
      .ctl    (mac_ctl),
      .sample (load_sample),
      .coef   (coef_sel),
      .acc    (acc)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Tap 0 is the newest sample; the rest come out of the delay line
   assign load_sample = (tap_ff == '0) ? newest_ff : dl_sample;
   assign coef_sel    = COEF_BITS'(flp49_pkg::tap_coef(int'(tap_ff), COEF_FRAC_BITS));

   // Drop the fraction bits toward zero: shift the magnitude, keep the sign apart
   assign acc_abs = acc[ACC_BITS-1] ? ACC_BITS'(-acc) : ACC_BITS'(acc);
   assign acc_int = CMP_BITS'(acc_abs >> COEF_FRAC_BITS);

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      digit_in     = digit_ff;
      newest_in    = newest_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      dl_ctl       = '0;
      mac_ctl      = '0;

      // Drop the held result once the rsp transfer completes
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               newest_in     = SAMPLE_BITS'(req_sample_mv);
               tap_in        = '0;
               mac_ctl.clear = 1'b1;
               dl_ctl.start  = 1'b1;
               state_in      = ST_READ;
            end
         end
         ST_READ: begin
            // Fold the previous tap's product while the memory read runs
            mac_ctl.add    = 1'b1;
            dl_ctl.advance = (tap_ff != '0);
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            mac_ctl.load = 1'b1;
            digit_in     = '0;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            mac_ctl.step = 1'b1;
            digit_in     = digit_ff + 1'b1;
            if (digit_ff == LAST_DIGIT) begin
               if (tap_ff == LAST_TAP) begin
                  state_in = ST_SUM;
               end else begin
                  tap_in   = tap_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_SUM: begin
            mac_ctl.add = 1'b1;
            dl_ctl.push = 1'b1;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            // Saturate the magnitude to the 14-bit range for its sign
            neg_in = acc[ACC_BITS-1];
            if (acc[ACC_BITS-1]) begin
               mag_in = (acc_int > NEG_LIMIT) ? MAG_BITS'(NEG_LIMIT) : MAG_BITS'(acc_int);
            end else begin
               mag_in = (acc_int > POS_LIMIT) ? MAG_BITS'(POS_LIMIT) : MAG_BITS'(acc_int);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold here while the output register still carries an untaken result
            if (out_free) begin
               rsp_data_in  = neg_ff ? OUT_BITS'(-mag_ff) : OUT_BITS'(mag_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         digit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         digit_ff     <= digit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      newest_ff   <= newest_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_filtered_mv = $signed(rsp_data_ff);

`ifndef NO_ASSERTIONS
   // A req transfer starts the tap sweep at tap 0
   a_start_sweep: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_READ) && (tap_ff == '0))
      else $error("tap sweep did not start after req transfer");

   // The final sum follows the last digit of the last tap
   a_sum_after_last_tap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUM) |-> ($past(state_ff) == ST_MULT) && ($past(tap_ff) == LAST_TAP)
         && ($past(digit_ff) == LAST_DIGIT))
      else $error("final sum reached before all taps were done");

   // The output register fills only from the finishing state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the finishing state");
`endif

endmodule

`default_nettype wire
